[hw/rtl/gsbp_pkg.sv]
`default_nettype none
package gsbp_pkg;

    localparam int DEF_MAX_RECORDS = 64;
    localparam int DEF_MAX_WORKERS = 16;

    localparam int SIZE_W   = 24;
    localparam int TOTAL_W  = 30;
    localparam int LOAD_W   = 31;
    localparam int CFG_W    = 5;
    localparam int WORKER_W = 4;
    localparam int INDEX_W  = 7;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(1);

    typedef struct packed {
        logic ld;
        logic div_init;
        logic div_step;
        logic wk_init;
        logic wk_next;
        logic scan_init;
        logic scan_step;
        logic decide;
        logic out_init;
        logic out_load;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic cont;
        logic scan_done;
        logic found;
        logic last_worker;
        logic out_free;
        logic out_last;
    } t_stat;

endpackage
`default_nettype wire

[hw/rtl/gsbp_ctrl.sv]
`default_nettype none
module gsbp_ctrl import gsbp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire logic  i_last_record,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_stall
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIVI   = 4'd1;
    localparam logic [3:0] S_DIV    = 4'd2;
    localparam logic [3:0] S_WSTART = 4'd3;
    localparam logic [3:0] S_PCHK   = 4'd4;
    localparam logic [3:0] S_SCANI  = 4'd5;
    localparam logic [3:0] S_SCAN   = 4'd6;
    localparam logic [3:0] S_DECIDE = 4'd7;
    localparam logic [3:0] S_WNEXT  = 4'd8;
    localparam logic [3:0] S_OINIT  = 4'd9;
    localparam logic [3:0] S_ORD    = 4'd10;
    localparam logic [3:0] S_OWAIT  = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.ld = 1'b1;
                    if (i_last_record) begin
                        n_state = S_DIVI;
                    end
                end
            end
            S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_WSTART;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_WSTART: begin
                o_cmd.wk_init = 1'b1;
                n_state = S_PCHK;
            end
            S_PCHK: begin
                n_state = i_stat.cont ? S_SCANI : S_WNEXT;
            end
            S_SCANI: begin
                o_cmd.scan_init = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.found) begin
                    o_cmd.decide = 1'b1;
                    n_state = S_PCHK;
                end else begin
                    n_state = S_WNEXT;
                end
            end
            S_WNEXT: begin
                if (i_stat.last_worker) begin
                    n_state = S_OINIT;
                end else begin
                    o_cmd.wk_next = 1'b1;
                    n_state = S_WSTART;
                end
            end
            S_OINIT: begin
                o_cmd.out_init = 1'b1;
                n_state = S_ORD;
            end
            S_ORD: begin
                n_state = S_OWAIT;
            end
            S_OWAIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_stat.out_last) begin
                        o_cmd.clear = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/gsbp_dp.sv]
`default_nettype none
module gsbp_dp import gsbp_pkg::*; #(
    parameter int MAX_RECORDS = DEF_MAX_RECORDS,
    parameter int MAX_WORKERS = DEF_MAX_WORKERS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    input  wire logic [CFG_W-1:0]    i_cfg_data,
    input  wire logic [SIZE_W-1:0]   i_record_size,
    input  wire logic                i_stall,
    input  wire t_cmd                i_cmd,
    output t_stat                    o_stat,
    output logic                     o_valid,
    output logic [INDEX_W-1:0]       o_record_index,
    output logic [WORKER_W-1:0]      o_worker,
    output logic                     o_last_result
);

    localparam int AW  = $clog2(MAX_RECORDS);
    localparam int CW  = $clog2(MAX_RECORDS + 1);
    localparam int DCW = $clog2(TOTAL_W + 1);

    logic [CFG_W-1:0]    r_cfg;
    logic [CW-1:0]       r_count;
    logic [TOTAL_W-1:0]  r_total;
    logic [MAX_RECORDS-1:0] r_pending;
    logic [MAX_RECORDS-1:0] r_skip;

    logic [SIZE_W-1:0]   r_size_mem [MAX_RECORDS];
    logic [WORKER_W-1:0] r_aw_mem   [MAX_RECORDS];
    logic [SIZE_W-1:0]   r_size_rd;
    logic [WORKER_W-1:0] r_aw_rd;

    logic [CW-1:0]       r_k;
    logic [DCW-1:0]      r_div_cnt;
    logic                r_p_live;
    logic                r_p_cand;
    logic                r_best_v;
    logic                r_o_valid;

    logic [CFG_W-1:0]    r_workers;
    logic [WORKER_W-1:0] r_w;
    logic [TOTAL_W-1:0]  r_quot;
    logic [CFG_W-1:0]    r_rem;
    logic [LOAD_W-1:0]   r_load;
    logic [AW-1:0]       r_p_idx;
    logic [AW-1:0]       r_best_idx;
    logic [SIZE_W-1:0]   r_best_size;
    logic [INDEX_W-1:0]  r_o_index;
    logic [WORKER_W-1:0] r_o_worker;
    logic                r_o_last;

    logic [AW-1:0]       addr;
    logic [AW-1:0]       wr_addr;
    logic                room;
    logic [TOTAL_W:0]    tot_sum;
    logic [CFG_W-1:0]    eff_workers;
    logic [CFG_W:0]      rem_sh;
    logic                rem_ge;
    logic [CFG_W:0]      rem_diff;
    logic [LOAD_W-1:0]   load_sum;
    logic                fits;
    logic                last_w;
    logic [CW-1:0]       k_inc;
    logic                take;
    logic                better;

    assign addr    = r_k[AW-1:0];
    assign wr_addr = r_count[AW-1:0];
    assign room    = (r_count < CW'(MAX_RECORDS));
    assign tot_sum = (TOTAL_W+1)'(r_total) + (TOTAL_W+1)'(i_record_size);

    always_comb begin
        if (i_cfg_data == '0 && r_cfg == '0) begin
            eff_workers = CFG_W'(1);
        end else if (r_cfg == '0) begin
            eff_workers = CFG_W'(1);
        end else if (r_cfg > CFG_W'(MAX_WORKERS)) begin
            eff_workers = CFG_W'(MAX_WORKERS);
        end else begin
            eff_workers = r_cfg;
        end
    end

    // restoring divider, one quotient bit per cycle
    assign rem_sh   = {r_rem, r_quot[TOTAL_W-1]};
    assign rem_ge   = (rem_sh >= (CFG_W+1)'(r_workers));
    assign rem_diff = rem_sh - (CFG_W+1)'(r_workers);

    assign load_sum = r_load + LOAD_W'(r_best_size);
    assign fits     = (load_sum <= LOAD_W'(r_quot));
    assign last_w   = (CFG_W'(r_w) == (r_workers - CFG_W'(1)));
    assign k_inc    = r_k + CW'(1);
    assign take     = fits || (r_load == '0) || last_w;
    assign better   = r_p_live && r_p_cand && (!r_best_v || (r_size_rd > r_best_size));

    assign o_stat.div_done    = (r_div_cnt == '0);
    assign o_stat.cont        = (r_load <= LOAD_W'(r_quot)) || last_w;
    assign o_stat.scan_done   = (r_k == r_count) && !r_p_live;
    assign o_stat.found       = r_best_v;
    assign o_stat.last_worker = last_w;
    assign o_stat.out_free    = !r_o_valid || !i_stall;
    assign o_stat.out_last    = (k_inc == r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg     <= CFG_RESET;
            r_count   <= '0;
            r_total   <= '0;
            r_pending <= '0;
            r_skip    <= '0;
            r_k       <= '0;
            r_div_cnt <= '0;
            r_p_live  <= 1'b0;
            r_best_v  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            if (i_cmd.ld && room) begin
                r_pending[wr_addr] <= 1'b1;
                r_count <= r_count + CW'(1);
                r_total <= tot_sum[TOTAL_W] ? TOTAL_MAX : tot_sum[TOTAL_W-1:0];
            end
            if (i_cmd.div_init) begin
                r_div_cnt <= DCW'(TOTAL_W);
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt - DCW'(1);
            end
            if (i_cmd.wk_init) begin
                r_skip <= '0;
            end
            if (i_cmd.scan_init) begin
                r_k      <= '0;
                r_p_live <= 1'b0;
                r_best_v <= 1'b0;
            end else if (i_cmd.scan_step) begin
                if (r_k < r_count) begin
                    r_p_live <= 1'b1;
                    r_k      <= k_inc;
                end else begin
                    r_p_live <= 1'b0;
                end
                if (better) begin
                    r_best_v <= 1'b1;
                end
            end
            if (i_cmd.decide) begin
                if (take) begin
                    r_pending[r_best_idx] <= 1'b0;
                end else begin
                    r_skip[r_best_idx] <= 1'b1;
                end
            end
            if (i_cmd.out_init) begin
                r_k <= '0;
            end else if (i_cmd.out_load) begin
                r_k <= k_inc;
            end
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            if (i_cmd.clear) begin
                r_count   <= '0;
                r_total   <= '0;
                r_pending <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_workers <= eff_workers;
            r_w       <= '0;
            r_quot    <= r_total;
            r_rem     <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= rem_ge ? rem_diff[CFG_W-1:0] : rem_sh[CFG_W-1:0];
            r_quot <= {r_quot[TOTAL_W-2:0], rem_ge};
        end
        if (i_cmd.wk_next) begin
            r_w <= r_w + WORKER_W'(1);
        end
        if (i_cmd.wk_init) begin
            r_load <= '0;
        end else if (i_cmd.decide && take) begin
            r_load <= load_sum;
        end
        if (i_cmd.scan_step) begin
            r_p_cand <= r_pending[addr] && !r_skip[addr];
            r_p_idx  <= addr;
            if (better) begin
                r_best_idx  <= r_p_idx;
                r_best_size <= r_size_rd;
            end
        end
        if (i_cmd.out_load) begin
            r_o_index  <= INDEX_W'(r_k) + INDEX_W'(1);
            r_o_worker <= r_aw_rd;
            r_o_last   <= (k_inc == r_count);
        end
    end

    // record sizes, read one entry a cycle during the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld && room) begin
            r_size_mem[wr_addr] <= i_record_size;
        end
        r_size_rd <= r_size_mem[addr];
    end

    // worker of each record
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide && take) begin
            r_aw_mem[r_best_idx] <= r_w;
        end
        r_aw_rd <= r_aw_mem[addr];
    end

    assign o_valid        = r_o_valid;
    assign o_record_index = r_o_index;
    assign o_worker       = r_o_worker;
    assign o_last_result  = r_o_last;

endmodule
`default_nettype wire

[hw/rtl/greedy_size_balanced_partition.sv]
// Loading: records are accepted back to back while the set is open; records past MAX_RECORDS are dropped.
// Partition after the final record: a restoring division of the total by the worker count
// gives the target (one quotient bit a cycle), then largest-first passes assign each worker.
// Output: per result, a worker memory read state, then a load state that waits out backpressure.
// Reset is synchronous, active low: clears counts, pending bits, output valid and sets
// worker_count to 1; the size and worker memories keep their contents.
`default_nettype none
module greedy_size_balanced_partition import gsbp_pkg::*; #(
    parameter int MAX_RECORDS = DEF_MAX_RECORDS,
    parameter int MAX_WORKERS = DEF_MAX_WORKERS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    input  wire logic [CFG_W-1:0]    i_cfg_data,
    output logic                     o_cfg_ready,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [SIZE_W-1:0]   i_record_size,
    input  wire logic                i_last_record,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [INDEX_W-1:0]       o_record_index,
    output logic [WORKER_W-1:0]      o_worker,
    output logic                     o_last_result
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    gsbp_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_last_record (i_last_record),
        .i_stat        (stat),
        .o_cmd         (cmd),
        .o_stall       (o_stall)
    );

    gsbp_dp #(
        .MAX_RECORDS (MAX_RECORDS),
        .MAX_WORKERS (MAX_WORKERS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_record_size  (i_record_size),
        .i_stall        (i_stall),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_record_index (o_record_index),
        .o_worker       (o_worker),
        .o_last_result  (o_last_result)
    );

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;
    import gsbp_pkg::*;

    localparam int MAX_REC     = DEF_MAX_RECORDS;
    localparam int MAX_WRK     = DEF_MAX_WORKERS;
    localparam int RAND_ITEMS  = 290;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 40;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int MAX_REPORTS = 10;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_mode;

    typedef struct {
        logic [SIZE_W-1:0] size;
        logic              last;
    } t_record;

    typedef struct {
        logic [INDEX_W-1:0]  index;
        logic [WORKER_W-1:0] worker;
        logic                last;
    } t_assignment;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_cfg_valid    = 1'b0;
    logic [CFG_W-1:0]    i_cfg_data     = '0;
    logic                o_cfg_ready;
    logic                i_valid        = 1'b0;
    logic                o_stall;
    logic [SIZE_W-1:0]   i_record_size  = '0;
    logic                i_last_record  = 1'b0;
    logic                o_valid;
    logic                i_stall        = 1'b0;
    logic [INDEX_W-1:0]  o_record_index;
    logic [WORKER_W-1:0] o_worker;
    logic                o_last_result;

    greedy_size_balanced_partition dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_cfg_ready    (o_cfg_ready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_record_size  (i_record_size),
        .i_last_record  (i_last_record),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_record_index (o_record_index),
        .o_worker       (o_worker),
        .o_last_result  (o_last_result)
    );

    always #2 i_clk = ~i_clk;

    // Shadow of the partition state
    logic [SIZE_W-1:0]   size_mem [MAX_REC];
    logic [WORKER_W-1:0] owner_mem [MAX_REC];
    logic [MAX_REC-1:0]  waiting        = '0;
    int                  set_count      = 0;
    logic [TOTAL_W-1:0]  set_total      = '0;
    logic [CFG_W-1:0]    worker_setting = CFG_RESET;

    t_assignment assignments_due [$];
    t_record     records_pending [$];

    int  errors     = 0;
    bit  hold_armed = 1'b0;

    function automatic void balance_set();
        int                 nworkers;
        logic [63:0]        target;
        logic [63:0]        load;
        logic [MAX_REC-1:0] passed_over;
        int                 best;
        bit                 final_worker;
        t_assignment        a;
        nworkers = (worker_setting == 0) ? 1 :
                   (worker_setting > MAX_WRK) ? MAX_WRK : int'(worker_setting);
        target = 64'(set_total) / 64'(nworkers);
        for (int w = 0; w < nworkers; w++) begin
            final_worker = (w == nworkers - 1);
            load = '0;
            passed_over = '0;
            while (load <= target || final_worker) begin
                best = -1;
                // largest waiting record, lower index wins a tie
                for (int k = 0; k < set_count; k++) begin
                    if (waiting[k] && !passed_over[k] &&
                        (best < 0 || size_mem[k] > size_mem[best]))
                        best = k;
                end
                if (best < 0)
                    break;
                if (load + size_mem[best] <= target || load == 0 || final_worker) begin
                    owner_mem[best] = WORKER_W'(w);
                    waiting[best] = 1'b0;
                    load += size_mem[best];
                end else begin
                    passed_over[best] = 1'b1;
                end
            end
        end
        for (int k = 0; k < set_count; k++) begin
            a.index  = INDEX_W'(k + 1);
            a.worker = owner_mem[k];
            a.last   = (k + 1 == set_count);
            assignments_due = {assignments_due, a};
        end
        waiting   = '0;
        set_count = 0;
        set_total = '0;
    endfunction

    function automatic void take_record(logic [SIZE_W-1:0] size, logic last);
        logic [TOTAL_W:0] sum;
        // drop records once the set is full
        if (set_count < MAX_REC) begin
            size_mem[set_count] = size;
            waiting[set_count]  = 1'b1;
            set_count++;
            sum = {1'b0, set_total} + size;
            set_total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        end
        if (last)
            balance_set();
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return {SIZE_W{1'b1}};
            2, 3:    return SIZE_W'($urandom_range(0, 7));
            4, 5:    return SIZE_W'($urandom_range(0, 4095));
            default: return SIZE_W'($urandom());
        endcase
    endfunction

    // Sender: bursts of transfers separated by random gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        t_record r;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                take_record(i_record_size, i_last_record);
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (records_pending.size() > 0) begin
                    r = records_pending.pop_front();
                    i_valid       <= 1'b1;
                    i_record_size <= r.size;
                    i_last_record <= r.last;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each transfer, stall on a changing pattern
    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          hold_left  = 0;
    bit          hold_used  = 1'b0;

    always @(posedge i_clk) begin
        t_assignment want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (assignments_due.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("unexpected result: index %0d worker %0d last %0b",
                                 o_record_index, o_worker, o_last_result);
                end else begin
                    want = assignments_due.pop_front();
                    if (o_record_index !== want.index || o_worker !== want.worker ||
                        o_last_result !== want.last) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("mismatch: index %0d/%0d worker %0d/%0d last %0b/%0b",
                                     want.index, o_record_index, want.worker, o_worker,
                                     want.last, o_last_result);
                    end
                end
            end
            // hold off once so the block backs up into its input
            if (hold_armed && !hold_used && assignments_due.size() > 0) begin
                hold_used = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    STALL_NONE:  i_stall <= 1'b0;
                    STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                    default:     i_stall <= !i_stall;
                endcase
            end
        end
    end

    task automatic write_workers(input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        worker_setting = value;
    endtask

    task automatic push_rec(input logic [SIZE_W-1:0] size, input logic last);
        t_record r;
        r.size = size;
        r.last = last;
        records_pending = {records_pending, r};
    endtask

    task automatic queue_set(input int len, input bit all_max);
        for (int k = 0; k < len; k++)
            push_rec(all_max ? {SIZE_W{1'b1}} : pick_size(), k == len - 1);
    endtask

    // Wait until every record is in and every assignment is out
    task automatic drain();
        while (records_pending.size() != 0 || i_valid || assignments_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    initial begin
        int               fed;
        int               phase;
        int               nsets;
        int               len;
        logic [CFG_W-1:0] wc;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // worker count at its reset value: single record, then extremes
        push_rec(24'd5, 1'b1);
        push_rec(24'hFFFFFF, 1'b0);
        push_rec(24'd0, 1'b0);
        push_rec(24'h800000, 1'b1);
        drain();
        // zero workers acts as one; equal sizes
        write_workers(5'd0);
        push_rec(24'd7, 1'b0);
        push_rec(24'd7, 1'b0);
        push_rec(24'd7, 1'b0);
        push_rec(24'd3, 1'b1);
        drain();
        // more workers than records
        write_workers(5'd16);
        push_rec(24'd0, 1'b0);
        push_rec(24'd0, 1'b1);
        push_rec(24'hFFFFFF, 1'b0);
        push_rec(24'd1, 1'b0);
        push_rec(24'd1, 1'b0);
        push_rec(24'hFFFFFF, 1'b0);
        push_rec(24'd2, 1'b1);
        drain();
        // above the maximum, clamps to sixteen
        write_workers(5'd31);
        push_rec(24'd50, 1'b0);
        push_rec(24'd40, 1'b0);
        push_rec(24'd30, 1'b0);
        push_rec(24'd20, 1'b0);
        push_rec(24'd10, 1'b1);
        drain();
        // records that overshoot the target wait for later workers
        write_workers(5'd3);
        push_rec(24'd9, 1'b0);
        push_rec(24'd8, 1'b0);
        push_rec(24'd7, 1'b0);
        push_rec(24'd6, 1'b0);
        push_rec(24'd5, 1'b0);
        push_rec(24'd4, 1'b1);
        drain();

        fed   = 0;
        phase = 0;
        while (fed < RAND_ITEMS) begin
            case (phase)
                0:       wc = 5'd1;
                1:       wc = 5'd16;
                2:       wc = 5'd0;
                3:       wc = 5'd31;
                4:       wc = 5'd17;
                5:       wc = 5'd4;
                default: wc = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 31))
                                                         : CFG_W'($urandom_range(1, 8));
            endcase
            write_workers(wc);
            nsets = $urandom_range(1, 4);
            if (phase == 2) begin
                hold_armed = 1'b1;
                nsets = 5;
            end
            for (int s = 0; s < nsets && fed < RAND_ITEMS; s++) begin
                if (phase == 4 && s == 0)
                    len = MAX_REC;
                else if (phase == 5 && s == 0)
                    len = MAX_REC + 6;
                else if ($urandom_range(0, 5) == 0)
                    len = $urandom_range(11, 30);
                else
                    len = $urandom_range(1, 10);
                queue_set(len, phase == 4 && s == 0);
                fed += len;
            end
            drain();
            phase++;
        end

        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_top: errors");
        $finish;
    end

endmodule
